// File: rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the sample voice mixer
// Commands, status codes, state encoding and the voice gain table.
// ----------------------------------------------------------------------------
`default_nettype none
package svm_pkg;
  localparam int Voices     = 8;
  localparam int VoiceW     = 3;
  localparam int FrameDepth = 65536;
  localparam int FrameAw    = 16;
  localparam int PosW       = 34;
  localparam int CountW     = 4;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NO_VOICE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_VREAD, S_VWAIT, S_VMUL, S_VDIV, S_VQUO, S_VACC,
    S_GAIN, S_SAT, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat
    logic exec;     // do non-tick command / tick setup
    logic vread;    // issue frame read for current voice
    logic vmul;     // pick channel value
    logic vdiv;     // velocity product
    logic vquo;     // coarse quotient of the divide by 127
    logic vacc;     // finish quotient, accumulate and advance voice
    logic gain;     // sum * gain
    logic sat;      // scale and saturate
  } svm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic no_voice;
    logic voice_live;  // current voice exists, is active and not at its end
    logic last_voice;
  } svm_stat_t;

  function automatic logic [16:0] gain_q16(input logic [CountW-1:0] n);
    logic [16:0] g;
    unique case (n)
      4'd0: g = 17'd0;
      4'd1: g = 17'd65536;
      4'd2: g = 17'd46341;
      4'd3: g = 17'd37837;
      4'd4: g = 17'd32768;
      4'd5: g = 17'd29309;
      4'd6: g = 17'd26755;
      4'd7: g = 17'd24770;
      4'd8: g = 17'd23170;
      4'd9: g = 17'd21845;
      4'd10: g = 17'd20724;
      4'd11: g = 17'd19760;
      4'd12: g = 17'd18919;
      4'd13: g = 17'd18176;
      4'd14: g = 17'd17515;
      default: g = 17'd16921;
    endcase
    return g;
  endfunction
endpackage
`default_nettype wire

// File: rtl/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_ram #(
  parameter int Width = 64,
  parameter int Depth = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl: command sequencer
// Steps one beat through execute and, for a tick, the per-voice loop, gain and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output svm_pkg::svm_cmd_t      cmd,
  input  wire svm_pkg::svm_stat_t stat
);
  svm_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svm_pkg::S_IDLE:  if (in_tvalid) state_nxt = svm_pkg::S_EXEC;
      svm_pkg::S_EXEC: begin
        if (!stat.is_tick || stat.no_voice) state_nxt = svm_pkg::S_OUT;
        else state_nxt = svm_pkg::S_VREAD;
      end
      svm_pkg::S_VREAD: begin
        if (stat.voice_live) state_nxt = svm_pkg::S_VWAIT;
        else if (stat.last_voice) state_nxt = svm_pkg::S_GAIN;
      end
      svm_pkg::S_VWAIT: state_nxt = svm_pkg::S_VMUL;
      svm_pkg::S_VMUL:  state_nxt = svm_pkg::S_VDIV;
      svm_pkg::S_VDIV:  state_nxt = svm_pkg::S_VQUO;
      svm_pkg::S_VQUO:  state_nxt = svm_pkg::S_VACC;
      svm_pkg::S_VACC: begin
        if (stat.last_voice) state_nxt = svm_pkg::S_GAIN;
        else state_nxt = svm_pkg::S_VREAD;
      end
      svm_pkg::S_GAIN:  state_nxt = svm_pkg::S_SAT;
      svm_pkg::S_SAT:   state_nxt = svm_pkg::S_OUT;
      svm_pkg::S_OUT:   if (out_tready) state_nxt = svm_pkg::S_IDLE;
      default:          state_nxt = svm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      svm_pkg::S_IDLE:  begin in_tready = 1'b1; cmd.load = in_tvalid; end
      svm_pkg::S_EXEC:  cmd.exec = 1'b1;
      svm_pkg::S_VREAD: cmd.vread = 1'b1;
      svm_pkg::S_VMUL:  cmd.vmul = 1'b1;
      svm_pkg::S_VDIV:  cmd.vdiv = 1'b1;
      svm_pkg::S_VQUO:  cmd.vquo = 1'b1;
      svm_pkg::S_VACC:  cmd.vacc = 1'b1;
      svm_pkg::S_GAIN:  cmd.gain = 1'b1;
      svm_pkg::S_SAT:   cmd.sat = 1'b1;
      svm_pkg::S_OUT:   out_tvalid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/svm_dpath.sv
// ----------------------------------------------------------------------------
// svm_dpath: mixer datapath
// Voice registers, frame memory, voice arithmetic, gain and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3:0]         cfg_voice_count,
  input  wire logic [151:0]       in_data,
  input  wire svm_pkg::svm_cmd_t  cmd,
  output svm_pkg::svm_stat_t      stat,
  output logic [31:0]             mixed_sample,
  output logic [1:0]              status,
  output logic [3:0]              active_voices
);
  // captured beat
  logic [151:0] beat_r;
  logic [2:0]   op;
  logic [15:0]  b_addr, b_start;
  logic [31:0]  b_left, b_right;
  logic [2:0]   b_sel;
  logic [16:0]  b_end;
  logic [23:0]  b_pitch;
  logic [6:0]   b_vel;
  logic         b_stereo;
  assign op       = beat_r[2:0];
  assign b_addr   = beat_r[18:3];
  assign b_left   = beat_r[50:19];
  assign b_right  = beat_r[82:51];
  assign b_sel    = beat_r[85:83];
  assign b_start  = beat_r[101:86];
  assign b_end    = beat_r[118:102];
  assign b_pitch  = beat_r[142:119];
  assign b_vel    = beat_r[149:143];
  assign b_stereo = beat_r[150];

  logic [15:0] v_start_r [svm_pkg::Voices];
  logic [16:0] v_end_r   [svm_pkg::Voices];
  logic [23:0] v_pitch_r [svm_pkg::Voices];
  logic [6:0]  v_vel_r   [svm_pkg::Voices];
  logic [svm_pkg::Voices-1:0] v_stereo_r, v_active_r;
  logic [svm_pkg::PosW-1:0] v_pos_r [svm_pkg::Voices];

  logic [3:0]  n_r, vi_r, act_r;
  logic [2:0]  vi;
  logic signed [37:0] sum_r;
  logic signed [32:0] val_r;
  logic signed [39:0] prod_r;
  logic [39:0] pabs_r;
  logic [31:0] q0_r;
  logic        neg_r;
  logic signed [55:0] mix_r;
  logic [31:0] mixed_r;
  logic [1:0]  status_r;

  assign vi = vi_r[2:0];

  // frame memory
  logic        ram_we;
  logic [15:0] ram_addr;
  logic [63:0] ram_rdata;
  assign ram_we   = cmd.exec && (op == svm_pkg::CMD_WRITE);
  assign ram_addr = ram_we ? b_addr : v_pos_r[vi][31:16];
  svm_ram #(.Width(64), .Depth(svm_pkg::FrameDepth)) u_frames (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({b_right, b_left}), .rdata(ram_rdata)
  );

  logic live, at_end, last, reject;
  assign live   = (vi_r < 4'(svm_pkg::Voices)) && v_active_r[vi];
  assign at_end = v_pos_r[vi] >= {1'b0, v_end_r[vi], 16'd0};
  assign last   = (vi_r + 4'd1) >= n_r;
  assign reject = (b_start > b_end[15:0]) || b_end[16] || (b_end[16:0] > 17'd65535);
  assign stat.is_tick    = (op == svm_pkg::CMD_TICK);
  assign stat.no_voice   = (cfg_voice_count == 4'd0);
  assign stat.voice_live = live && !at_end;
  assign stat.last_voice = last;

  // channel average, truncated toward zero
  logic signed [32:0] lsum, avg;
  always_comb begin
    lsum = $signed({ram_rdata[31], ram_rdata[31:0]})
         + $signed({ram_rdata[63], ram_rdata[63:32]});
    avg  = (lsum + $signed({32'd0, lsum[32] & lsum[0]})) >>> 1;
  end

  // divide by 127 on the magnitude: a coarse quotient from the series
  // 1/127 = 1/128 + 1/128^2 + ..., which falls short by at most 6, then a
  // fix-up from the small remainder
  logic [39:0] pabs, q0_sum, rem_full;
  logic [9:0]  rem;
  logic [10:0] qfix;
  logic [32:0] quo;
  logic signed [33:0] sq;
  always_comb begin
    pabs     = prod_r[39] ? 40'(-prod_r) : 40'(prod_r);
    q0_sum   = (pabs >> 7) + (pabs >> 14) + (pabs >> 21) + (pabs >> 28) + (pabs >> 35);
    rem_full = pabs_r - ((40'(q0_r) << 7) - 40'(q0_r));
    rem      = rem_full[9:0];
    qfix     = {1'b0, rem} + {8'd0, rem[9:7]} + 11'd1;
    quo      = {1'b0, q0_r} + {29'd0, qfix[10:7]};
    sq       = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  // scale by 1/65536 truncated toward zero
  logic signed [55:0] mix_r_q;
  assign mix_r_q = (mix_r + (mix_r[55] ? 56'sd65535 : 56'sd0)) >>> 16;

  // sequential state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < svm_pkg::Voices; i++) begin
        v_start_r[i] <= '0; v_end_r[i] <= '0; v_pitch_r[i] <= 24'd65536;
        v_vel_r[i] <= 7'd100; v_pos_r[i] <= '0;
      end
      v_stereo_r <= '0;
      v_active_r <= '0;
      status_r   <= svm_pkg::ST_OK;
      mixed_r    <= '0;
      act_r      <= '0;
    end else begin
      if (cmd.exec) begin
        status_r <= svm_pkg::ST_OK;
        mixed_r  <= '0;
        act_r    <= '0;
        vi_r     <= '0;
        sum_r    <= '0;
        n_r      <= (cfg_voice_count > 4'(svm_pkg::Voices)) ? 4'(svm_pkg::Voices)
                                                             : cfg_voice_count;
        unique case (op)
          svm_pkg::CMD_SET: begin
            if (reject) status_r <= svm_pkg::ST_REJECT;
            else begin
              v_start_r[b_sel] <= b_start; v_end_r[b_sel] <= b_end;
              v_pitch_r[b_sel] <= b_pitch; v_vel_r[b_sel] <= b_vel;
              v_stereo_r[b_sel] <= b_stereo;
            end
          end
          svm_pkg::CMD_START: begin
            v_active_r[b_sel] <= 1'b1;
            v_pos_r[b_sel] <= {2'd0, v_start_r[b_sel], 16'd0};
          end
          svm_pkg::CMD_STOP: v_active_r[b_sel] <= 1'b0;
          svm_pkg::CMD_TICK:
            if (cfg_voice_count == 4'd0) status_r <= svm_pkg::ST_NO_VOICE;
          default: ;
        endcase
      end
      if (cmd.vread) begin
        if (live) act_r <= act_r + 4'd1;
        if (live && at_end) begin
          v_active_r[vi] <= 1'b0;
          v_pos_r[vi] <= {2'd0, v_start_r[vi], 16'd0};
        end
        if (!(live && !at_end)) vi_r <= vi_r + 4'd1;
      end
      if (cmd.vmul) begin
        val_r  <= v_stereo_r[vi] ? avg : $signed({ram_rdata[31], ram_rdata[31:0]});
      end
      if (cmd.vdiv) begin
        prod_r <= 40'(val_r * $signed({1'b0, v_vel_r[vi]}));
      end
      if (cmd.vquo) begin
        pabs_r <= pabs;
        q0_r   <= q0_sum[31:0];
        neg_r  <= prod_r[39];
      end
      if (cmd.vacc) begin
        sum_r <= sum_r + $signed({{4{sq[33]}}, sq});
        v_pos_r[vi] <= v_pos_r[vi] + 34'(v_pitch_r[vi]);
        vi_r  <= vi_r + 4'd1;
      end
      if (cmd.gain) begin
        mix_r <= 56'(sum_r * $signed({1'b0, svm_pkg::gain_q16(act_r)}));
      end
      if (cmd.sat) begin
        if (mix_r_q > 56'sd2147483647) mixed_r <= 32'h7fffffff;
        else if (mix_r_q < -56'sd2147483648) mixed_r <= 32'h80000000;
        else mixed_r <= mix_r_q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) beat_r <= in_data;
  end

  assign mixed_sample  = mixed_r;
  assign status        = status_r;
  assign active_voices = act_r;
endmodule
`default_nettype wire

// File: rtl/sample_voice_mixer_unit.sv
// ----------------------------------------------------------------------------
// sample_voice_mixer_unit: multi-voice sample playback mixer
// Shared frame memory, eight voices, sqrt-normalized mix with saturation.
// ----------------------------------------------------------------------------
// Non-tick commands and ticks with no voices go from accept through execute to the result.
// Tick: after execute, each playing voice steps through frame read, wait, channel pick,
// velocity product, divide by 127 and accumulate; each other slot below voice_count only
// through frame read; then gain and saturation. One beat in flight at a time; the next
// beat is accepted in the cycle after the result is taken. Synchronous active-low reset
// clears voice settings to defaults and voice_count to 0; frame memory is not cleared.
`default_nettype none
module sample_voice_mixer_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [3:0]   cfg_wdata,   // voice_count
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd, frame_address, left_value, right_value, voice_select, start_frame,
  // end_frame, pitch_step, velocity, stereo (lowest first)
  input  wire logic [151:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // mixed_sample, status, active_voices (lowest first)
  output logic [39:0]       out_tdata
);
  logic [3:0] voice_count_r;
  svm_pkg::svm_cmd_t  cmd;
  svm_pkg::svm_stat_t stat;
  logic [31:0] mixed;
  logic [1:0]  st;
  logic [3:0]  act;

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) voice_count_r <= '0;
    else if (cfg_we) voice_count_r <= cfg_wdata;
  end

  svm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .stat(stat)
  );

  svm_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg_voice_count(voice_count_r), .in_data(in_tdata),
    .cmd(cmd), .stat(stat), .mixed_sample(mixed), .status(st), .active_voices(act)
  );

  assign out_tdata = {2'd0, act, st, mixed};

  // result never counts more voices than exist
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> act <= 4'd8)
    else $error("active voice count out of range");
  // no input taken while a result waits
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input accepted during output");
  // no-voice status carries a zero mix
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st == svm_pkg::ST_NO_VOICE) |-> (mixed == 32'd0 && act == 4'd0))
    else $error("no-voice tick with nonzero result");
endmodule
`default_nettype wire
